// ===== src/rmp_pkg.sv =====
// Package for the recursive mutex pool: request kinds, result status codes
// and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmp_pkg;

   // default sizes handed to the top level parameters
   localparam int NUM_MUTEXES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int PID_BITS_DEF    = 16;
   localparam int NEST_BITS_DEF   = 8;

   // fixed field widths
   localparam int KIND_BITS   = 2;
   localparam int INDEX_BITS  = 4;
   localparam int STATUS_BITS = 3;

   // request kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOCK    = 2'd0,
      KIND_TRYLOCK = 2'd1,
      KIND_UNLOCK  = 2'd2
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      ST_ACQUIRED  = 3'd0,
      ST_NESTED    = 3'd1,
      ST_QUEUED    = 3'd2,
      ST_BUSY      = 3'd3,
      ST_RELEASED  = 3'd4,
      ST_NOT_OWNER = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

endpackage

`default_nettype wire

// ===== src/rmp_ram.sv =====
// Generic single-write, single-read RAM with registered read data and read enable.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/recursive_mutex_pool.sv =====
// Top level of the recursive mutex pool: per-mutex owner, nesting and queue state,
// request pipeline and result register. Depends on rmp_pkg and rmp_ram.
`timescale 1ns / 1ps
`default_nettype none

// One request in, one result out. A new request can be taken every cycle while
// the result register is not stalled; a request passes the read stage, which
// reads the head waiter from the waiter RAM, whose read data is registered, and
// the decide stage, which updates the mutex entry and loads the result register.
// Owner, nesting count and queue pointers of every mutex sit in flip-flops
// and are cleared by reset, so the pool is usable in the first cycle after
// reset. Waiter ids live in a RAM of NUM_MUTEXES slices of QUEUE_DEPTH
// entries; a request that follows one to the same mutex gets the fresh head
// pointer and, if needed, the just-written waiter id by forwarding.
module recursive_mutex_pool #(
   parameter int NUM_MUTEXES = rmp_pkg::NUM_MUTEXES_DEF,
   parameter int QUEUE_DEPTH = rmp_pkg::QUEUE_DEPTH_DEF,
   parameter int PID_BITS    = rmp_pkg::PID_BITS_DEF,
   parameter int NEST_BITS   = rmp_pkg::NEST_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rmp_pkg::KIND_BITS-1:0]    req_kind,
   input  wire logic [rmp_pkg::INDEX_BITS-1:0]   req_mutex_index,
   input  wire logic [PID_BITS-1:0]              req_requester_pid,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [rmp_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic                                  rsp_wake_valid,
   output logic      [PID_BITS-1:0]              rsp_wake_pid,
   output logic      [NEST_BITS-1:0]             rsp_nest_depth
);

   localparam int MW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = MW + QW;
   localparam int RAM_DEPTH = 2 ** AW;

   // per-mutex state
   logic [PID_BITS-1:0]  owner_ff [NUM_MUTEXES];
   logic [NEST_BITS-1:0] nest_ff  [NUM_MUTEXES];
   logic [QW-1:0]        head_ff  [NUM_MUTEXES];
   logic [QW-1:0]        tail_ff  [NUM_MUTEXES];
   logic [FW-1:0]        fill_ff  [NUM_MUTEXES];

   // read stage
   logic                            s1_valid_ff, s1_valid_in;
   logic [rmp_pkg::KIND_BITS-1:0]   s1_kind_ff;
   logic [rmp_pkg::INDEX_BITS-1:0]  s1_idx_ff;
   logic [PID_BITS-1:0]             s1_pid_ff;

   // decide stage
   logic                            s2_valid_ff, s2_valid_in;
   logic [rmp_pkg::KIND_BITS-1:0]   s2_kind_ff;
   logic [rmp_pkg::INDEX_BITS-1:0]  s2_idx_ff;
   logic [PID_BITS-1:0]             s2_pid_ff;
   logic                            s2_byp_ff, s2_byp_in;
   logic [PID_BITS-1:0]             s2_byp_pid_ff;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   rmp_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic                            rsp_wake_valid_ff, rsp_wake_valid_in;
   logic [PID_BITS-1:0]             rsp_wake_pid_ff, rsp_wake_pid_in;
   logic [NEST_BITS-1:0]            rsp_nest_depth_ff, rsp_nest_depth_in;

   // next values of the addressed entry
   logic [PID_BITS-1:0]  own_in;
   logic [NEST_BITS-1:0] nest_in;
   logic [QW-1:0]        head_in;
   logic [QW-1:0]        tail_in;
   logic [FW-1:0]        fill_in;

   logic                 req_fire, s1_adv, s2_fire, commit, push;
   logic [MW-1:0]        s1_m, s2_m;
   logic                 idx_ok;
   logic [PID_BITS-1:0]  own_cur;
   logic [NEST_BITS-1:0] nest_cur;
   logic [QW-1:0]        head_cur, tail_cur;
   logic [FW-1:0]        fill_cur;
   logic [PID_BITS-1:0]  waiter_pid, ram_rd_data;
   logic [QW-1:0]        rd_slot;
   logic [AW-1:0]        ram_rd_addr, ram_wr_addr;

   // pipeline flow control
   assign s2_fire   = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_fire);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   assign s1_m = MW'(s1_idx_ff);
   assign s2_m = MW'(s2_idx_ff);
   assign idx_ok = (32'(s2_idx_ff) < 32'(NUM_MUTEXES));
   assign commit = s2_fire && idx_ok;

   // current entry of the mutex in the decide stage
   assign own_cur  = owner_ff[s2_m];
   assign nest_cur = nest_ff[s2_m];
   assign head_cur = head_ff[s2_m];
   assign tail_cur = tail_ff[s2_m];
   assign fill_cur = fill_ff[s2_m];
   assign waiter_pid = s2_byp_ff ? s2_byp_pid_ff : ram_rd_data;

   // decide the request and the next entry
   always_comb begin
      own_in            = own_cur;
      nest_in           = nest_cur;
      head_in           = head_cur;
      tail_in           = tail_cur;
      fill_in           = fill_cur;
      push              = 1'b0;
      rsp_status_in     = rmp_pkg::ST_BUSY;
      rsp_wake_valid_in = 1'b0;
      rsp_wake_pid_in   = '0;
      unique case (s2_kind_ff)
         rmp_pkg::KIND_LOCK, rmp_pkg::KIND_TRYLOCK: begin
            if (s2_pid_ff == '0) begin
               rsp_status_in = rmp_pkg::ST_BUSY;
            end else if (own_cur == s2_pid_ff) begin
               if (nest_cur == {NEST_BITS{1'b1}}) begin
                  rsp_status_in = rmp_pkg::ST_FULL;
               end else begin
                  nest_in       = nest_cur + NEST_BITS'(1);
                  rsp_status_in = rmp_pkg::ST_NESTED;
               end
            end else if (own_cur == '0) begin
               own_in        = s2_pid_ff;
               nest_in       = NEST_BITS'(1);
               rsp_status_in = rmp_pkg::ST_ACQUIRED;
            end else if (s2_kind_ff == rmp_pkg::KIND_TRYLOCK) begin
               rsp_status_in = rmp_pkg::ST_BUSY;
            end else if (fill_cur == FW'(QUEUE_DEPTH)) begin
               rsp_status_in = rmp_pkg::ST_FULL;
            end else begin
               push          = 1'b1;
               tail_in       = (tail_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + QW'(1);
               fill_in       = fill_cur + FW'(1);
               rsp_status_in = rmp_pkg::ST_QUEUED;
            end
         end
         rmp_pkg::KIND_UNLOCK: begin
            if (s2_pid_ff == '0 || own_cur != s2_pid_ff) begin
               rsp_status_in = rmp_pkg::ST_NOT_OWNER;
            end else if (nest_cur > NEST_BITS'(1)) begin
               nest_in       = nest_cur - NEST_BITS'(1);
               rsp_status_in = rmp_pkg::ST_RELEASED;
            end else begin
               rsp_status_in = rmp_pkg::ST_RELEASED;
               if (fill_cur != '0) begin
                  // hand straight to the head waiter
                  own_in            = waiter_pid;
                  nest_in           = NEST_BITS'(1);
                  head_in           = (head_cur == QW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + QW'(1);
                  fill_in           = fill_cur - FW'(1);
                  rsp_wake_valid_in = 1'b1;
                  rsp_wake_pid_in   = waiter_pid;
               end else begin
                  own_in  = '0;
                  nest_in = '0;
               end
            end
         end
         default: begin
            rsp_status_in = rmp_pkg::ST_BUSY;
         end
      endcase
      rsp_nest_depth_in = nest_in;
      if (!idx_ok) begin
         rsp_status_in     = rmp_pkg::ST_BUSY;
         rsp_wake_valid_in = 1'b0;
         rsp_wake_pid_in   = '0;
         rsp_nest_depth_in = '0;
      end
   end

   // head slot for the read stage, taking an update of the same mutex into account
   assign rd_slot     = (commit && s2_m == s1_m) ? head_in : head_ff[s1_m];
   assign ram_rd_addr = {s1_m, rd_slot};
   assign ram_wr_addr = {s2_m, tail_cur};

   // forward a waiter id written in the same cycle it is read
   assign s2_byp_in = commit && push && (ram_wr_addr == ram_rd_addr);

   rmp_ram #(
      .WIDTH(PID_BITS),
      .DEPTH(RAM_DEPTH)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (commit && push),
      .wr_addr (ram_wr_addr),
      .wr_data (s2_pid_ff),
      .rd_en   (s1_adv),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // stage valids
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_adv);
   assign s2_valid_in  = s1_adv || (s2_valid_ff && !s2_fire);
   assign rsp_valid_in = s2_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_kind;
         s1_idx_ff  <= req_mutex_index;
         s1_pid_ff  <= req_requester_pid;
      end
      if (s1_adv) begin
         s2_kind_ff    <= s1_kind_ff;
         s2_idx_ff     <= s1_idx_ff;
         s2_pid_ff     <= s1_pid_ff;
         s2_byp_ff     <= s2_byp_in;
         s2_byp_pid_ff <= s2_pid_ff;
      end
      if (s2_fire) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_wake_valid_ff <= rsp_wake_valid_in;
         rsp_wake_pid_ff   <= rsp_wake_pid_in;
         rsp_nest_depth_ff <= rsp_nest_depth_in;
      end
   end

   // mutex entries
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MUTEXES; i++) begin
            owner_ff[i] <= '0;
            nest_ff[i]  <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
      end else if (commit) begin
         owner_ff[s2_m] <= own_in;
         nest_ff[s2_m]  <= nest_in;
         head_ff[s2_m]  <= head_in;
         tail_ff[s2_m]  <= tail_in;
         fill_ff[s2_m]  <= fill_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_wake_valid = rsp_wake_valid_ff;
   assign rsp_wake_pid   = rsp_wake_pid_ff;
   assign rsp_nest_depth = rsp_nest_depth_ff;

endmodule

`default_nettype wire

// ===== src/rmp_checker.sv =====
// Port-level checks for the recursive mutex pool and the bind that attaches them.
// Depends on rmp_pkg and recursive_mutex_pool.
`timescale 1ns / 1ps
`default_nettype none

module rmp_checker #(
   parameter int PID_BITS  = rmp_pkg::PID_BITS_DEF,
   parameter int NEST_BITS = rmp_pkg::NEST_BITS_DEF
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [rmp_pkg::STATUS_BITS-1:0] rsp_status,
   input wire logic                            rsp_wake_valid,
   input wire logic [PID_BITS-1:0]             rsp_wake_pid,
   input wire logic [NEST_BITS-1:0]            rsp_nest_depth
);

   // a handoff only comes with a release and leaves the new owner at depth one
   a_wake_on_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wake_valid |->
         rsp_status == rmp_pkg::ST_RELEASED && rsp_nest_depth == NEST_BITS'(1)
         && rsp_wake_pid != '0)
      else $error("wake without a releasing unlock");

   // no woken id outside a handoff
   a_wake_pid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wake_valid |-> rsp_wake_pid == '0)
      else $error("wake id set without a handoff");

   // a fresh acquire starts at depth one
   a_acquire_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rmp_pkg::ST_ACQUIRED |-> rsp_nest_depth == NEST_BITS'(1))
      else $error("acquire with depth other than one");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_wake_pid) && $stable(rsp_nest_depth))
      else $error("result changed while stalled");

endmodule

bind recursive_mutex_pool rmp_checker #(
   .PID_BITS  (PID_BITS),
   .NEST_BITS (NEST_BITS)
) u_rmp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_wake_valid (rsp_wake_valid),
   .rsp_wake_pid   (rsp_wake_pid),
   .rsp_nest_depth (rsp_nest_depth)
);

`default_nettype wire
